// ----- src/cts_pkg.sv -----
// ----------------------------------------------------------------------------
// cts_pkg
// Types, constants and the microcode program of the Taylor-series cosine block.
// ----------------------------------------------------------------------------
`default_nettype none

package cts_pkg;

    // field widths
    localparam int TERM_W  = 4;
    localparam int ANGLE_W = 32;
    localparam int VAL_W   = 64;
    localparam int ACC_W   = 2 * VAL_W;
    localparam int HALF_W  = VAL_W / 2;

    // program counter
    localparam int PC_W      = 5;
    localparam int MUL_STEPS = 7;

    // offsets inside one multiply routine
    localparam logic [2:0] MUL_LD  = 3'd0;
    localparam logic [2:0] MUL_P00 = 3'd1;
    localparam logic [2:0] MUL_P01 = 3'd2;
    localparam logic [2:0] MUL_P10 = 3'd3;
    localparam logic [2:0] MUL_P11 = 3'd4;
    localparam logic [2:0] MUL_ACC = 3'd5;
    localparam logic [2:0] MUL_RND = 3'd6;

    // program entry points
    localparam logic [PC_W-1:0] ST_FETCH = '0;
    localparam logic [PC_W-1:0] ST_XX    = ST_FETCH + PC_W'(1);
    localparam logic [PC_W-1:0] ST_TR    = ST_XX + PC_W'(MUL_STEPS);
    localparam logic [PC_W-1:0] ST_TN    = ST_TR + PC_W'(MUL_STEPS);
    localparam logic [PC_W-1:0] ST_ADD   = ST_TN + PC_W'(MUL_STEPS);
    localparam logic [PC_W-1:0] ST_DONE  = ST_ADD + PC_W'(1);

    // operand pair for a multiply
    typedef enum logic [1:0] {
        SRC_XX,     // angle times angle
        SRC_TR,     // term times reciprocal
        SRC_TN      // term times minus angle squared
    } t_src;

    // where a rounded product goes
    typedef enum logic [1:0] {
        DST_NONE,
        DST_NEGX2,
        DST_TERM
    } t_dst;

    // accumulate alignment
    typedef enum logic [1:0] {
        SH_0,
        SH_32,
        SH_64
    } t_sh;

    // sequencer branch kinds
    typedef enum logic [2:0] {
        J_NEXT,
        J_IN_WAIT,
        J_ZERO,
        J_MORE,
        J_OUT_WAIT,
        J_GOTO
    } t_jmp;

    // one control word
    typedef struct packed {
        logic            in_rdy;
        logic            ld;
        t_src            src;
        logic            mul_en;
        logic            a_hi;
        logic            b_hi;
        logic            acc_en;
        t_sh             acc_sh;
        logic            rnd_en;
        t_dst            dst;
        logic            add_en;
        logic            out_wr;
        t_jmp            jmp;
        logic [PC_W-1:0] target;
    } t_ctrl;

    // datapath status for branching
    typedef struct packed {
        logic in_fire;
        logic out_free;
        logic left_zero;
        logic left_last;
    } t_stat;

    // one step of the four partial product multiply routine
    function automatic t_ctrl mul_step(input logic [2:0] k);
        t_ctrl c;
        c = '0;
        case (k)
            MUL_LD: begin
                c.ld = 1'b1;
            end
            MUL_P00: begin
                c.mul_en = 1'b1;
            end
            MUL_P01: begin
                c.mul_en = 1'b1;
                c.b_hi   = 1'b1;
                c.acc_en = 1'b1;
                c.acc_sh = SH_0;
            end
            MUL_P10: begin
                c.mul_en = 1'b1;
                c.a_hi   = 1'b1;
                c.acc_en = 1'b1;
                c.acc_sh = SH_32;
            end
            MUL_P11: begin
                c.mul_en = 1'b1;
                c.a_hi   = 1'b1;
                c.b_hi   = 1'b1;
                c.acc_en = 1'b1;
                c.acc_sh = SH_32;
            end
            MUL_ACC: begin
                c.acc_en = 1'b1;
                c.acc_sh = SH_64;
            end
            MUL_RND: begin
                c.rnd_en = 1'b1;
            end
            default: begin
                c = '0;
            end
        endcase
        return c;
    endfunction

    // program rom
    function automatic t_ctrl ucode(input logic [PC_W-1:0] pc);
        t_ctrl      c;
        logic [2:0] k;
        c = '0;
        k = '0;
        if (pc == ST_FETCH) begin
            c.in_rdy = 1'b1;
            c.jmp    = J_IN_WAIT;
        end else if (pc < ST_TR) begin
            k     = 3'(pc - ST_XX);
            c     = mul_step(k);
            c.src = SRC_XX;
            c.dst = DST_NEGX2;
            if (k == MUL_RND) begin
                c.jmp    = J_ZERO;
                c.target = ST_DONE;
            end
        end else if (pc < ST_TN) begin
            k     = 3'(pc - ST_TR);
            c     = mul_step(k);
            c.src = SRC_TR;
            c.dst = DST_TERM;
        end else if (pc < ST_ADD) begin
            k     = 3'(pc - ST_TN);
            c     = mul_step(k);
            c.src = SRC_TN;
            c.dst = DST_TERM;
        end else if (pc == ST_ADD) begin
            c.add_en = 1'b1;
            c.jmp    = J_MORE;
            c.target = ST_TR;
        end else if (pc == ST_DONE) begin
            c.out_wr = 1'b1;
            c.jmp    = J_OUT_WAIT;
            c.target = ST_FETCH;
        end else begin
            c.jmp    = J_GOTO;
            c.target = ST_FETCH;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- src/cts_if.sv -----
// ----------------------------------------------------------------------------
// cts_if
// Valid/ready channels of the cosine block: angle in, result out, config.
// ----------------------------------------------------------------------------
`default_nettype none

interface cts_in_if import cts_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] angle;

    modport source (output valid, output angle, input ready);
    modport sink   (input valid, input angle, output ready);
endinterface

interface cts_out_if import cts_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] value;
    logic                    saturated;

    modport source (output valid, output value, output saturated, input ready);
    modport sink   (input valid, input value, input saturated, output ready);
endinterface

interface cts_cfg_if import cts_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TERM_W-1:0] term_count;

    modport source (output valid, output term_count, input ready);
    modport sink   (input valid, input term_count, output ready);
endinterface

`default_nettype wire

// ----- src/cts_seq.sv -----
// ----------------------------------------------------------------------------
// cts_seq
// Microcode sequencer: step counter, program rom and branch logic.
// ----------------------------------------------------------------------------
`default_nettype none

module cts_seq import cts_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_stat i_stat,
    output t_ctrl      o_ctrl
);

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_ctrl           w_ctrl;

    // control word of the current step
    always_comb begin
        w_ctrl = ucode(r_pc);
    end

    assign o_ctrl = w_ctrl;

    // branch resolution
    always_comb begin
        n_pc = r_pc + PC_W'(1);
        case (w_ctrl.jmp)
            J_NEXT:     n_pc = r_pc + PC_W'(1);
            J_IN_WAIT:  n_pc = i_stat.in_fire ? r_pc + PC_W'(1) : r_pc;
            J_ZERO:     n_pc = i_stat.left_zero ? w_ctrl.target : r_pc + PC_W'(1);
            J_MORE:     n_pc = i_stat.left_last ? r_pc + PC_W'(1) : w_ctrl.target;
            J_OUT_WAIT: n_pc = i_stat.out_free ? w_ctrl.target : r_pc;
            J_GOTO:     n_pc = w_ctrl.target;
            default:    n_pc = ST_FETCH;
        endcase
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ST_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

`default_nettype wire

// ----- src/cts_dp.sv -----
// ----------------------------------------------------------------------------
// cts_dp
// Datapath: shared 32x32 multiplier, 128-bit accumulator, rounding and
// saturation, series sum, term count register and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cts_dp import cts_pkg::*; #(
    parameter int MAX_TERMS = 15,
    parameter int FRAC_BITS = 24
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_ctrl i_ctrl,
    output t_stat      o_stat,
    cts_in_if.sink     i_in,
    cts_out_if.source  o_out,
    cts_cfg_if.sink    i_cfg
);

    localparam logic [VAL_W-1:0] ONE   = VAL_W'(1) << FRAC_BITS;
    localparam logic [ACC_W-1:0] RND   = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic [VAL_W-1:0] S_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] S_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    // reciprocals of (2i-1)(2i), rounded, worked out at elaboration
    logic [VAL_W-1:0] w_recip [1:MAX_TERMS];

    for (genvar g = 1; g <= MAX_TERMS; g++) begin : g_rcp
        localparam longint unsigned DEN = longint'((2 * g - 1) * (2 * g));
        localparam logic [VAL_W-1:0] RCP = ((VAL_W'(1) << FRAC_BITS) + DEN / 2) / DEN;
        assign w_recip[g] = RCP;
    end

    // control registers
    logic [TERM_W-1:0] r_term_count;
    logic              r_out_valid;

    // payload registers
    logic signed [ANGLE_W-1:0] r_x;
    logic [VAL_W-1:0]          r_term;
    logic [VAL_W-1:0]          r_sum;
    logic [VAL_W-1:0]          r_negx2;
    logic [VAL_W-1:0]          r_ua;
    logic [VAL_W-1:0]          r_ub;
    logic                      r_neg;
    logic [ACC_W-1:0]          r_acc;
    logic [VAL_W-1:0]          r_prod;
    logic                      r_sat;
    logic [TERM_W-1:0]         r_left;
    logic [TERM_W-1:0]         r_i;
    logic [VAL_W-1:0]          r_value;
    logic                      r_osat;

    logic             w_in_fire;
    logic             w_out_free;
    logic [VAL_W-1:0] w_opa;
    logic [VAL_W-1:0] w_opb;
    logic [HALF_W-1:0] w_ha;
    logic [HALF_W-1:0] w_hb;
    logic [ACC_W-1:0] w_addend;
    logic             w_ovf;
    logic [VAL_W-1:0] w_q;
    logic [VAL_W-1:0] w_rnd_res;
    logic             w_rnd_sat;
    logic [VAL_W:0]   w_sum_ext;
    logic [VAL_W-1:0] w_add_res;
    logic             w_add_sat;
    logic [TERM_W-1:0] w_n;

    // handshakes
    assign w_in_fire    = i_ctrl.in_rdy && i_in.valid;
    assign i_in.ready   = i_ctrl.in_rdy;
    assign i_cfg.ready  = 1'b1;
    assign w_out_free   = !r_out_valid || o_out.ready;
    assign o_out.valid     = r_out_valid;
    assign o_out.value     = r_value;
    assign o_out.saturated = r_osat;

    assign o_stat.in_fire   = w_in_fire;
    assign o_stat.out_free  = w_out_free;
    assign o_stat.left_zero = (r_left == '0);
    assign o_stat.left_last = (r_left == TERM_W'(1));

    // term count clamped to the table size
    assign w_n = (r_term_count > TERM_W'(MAX_TERMS)) ? TERM_W'(MAX_TERMS) : r_term_count;

    // operand selection
    always_comb begin
        case (i_ctrl.src)
            SRC_XX: begin
                w_opa = VAL_W'(r_x);
                w_opb = VAL_W'(r_x);
            end
            SRC_TR: begin
                w_opa = r_term;
                w_opb = w_recip[r_i];
            end
            SRC_TN: begin
                w_opa = r_term;
                w_opb = r_negx2;
            end
            default: begin
                w_opa = r_term;
                w_opb = r_negx2;
            end
        endcase
    end

    // multiplier halves
    assign w_ha = i_ctrl.a_hi ? r_ua[VAL_W-1:HALF_W] : r_ua[HALF_W-1:0];
    assign w_hb = i_ctrl.b_hi ? r_ub[VAL_W-1:HALF_W] : r_ub[HALF_W-1:0];

    // partial product alignment
    always_comb begin
        case (i_ctrl.acc_sh)
            SH_0:    w_addend = {{VAL_W{1'b0}}, r_prod};
            SH_32:   w_addend = {{HALF_W{1'b0}}, r_prod, {HALF_W{1'b0}}};
            SH_64:   w_addend = {r_prod, {VAL_W{1'b0}}};
            default: w_addend = {{VAL_W{1'b0}}, r_prod};
        endcase
    end

    // rounding already in the accumulator, so only range check and sign here
    always_comb begin
        w_ovf     = |r_acc[ACC_W-1:VAL_W+FRAC_BITS];
        w_q       = w_ovf ? {VAL_W{1'b1}} : r_acc[FRAC_BITS +: VAL_W];
        w_rnd_sat = 1'b0;
        if (r_neg) begin
            if (w_q > S_MIN) begin
                w_rnd_sat = 1'b1;
                w_rnd_res = S_MIN;
            end else begin
                w_rnd_res = -w_q;
            end
        end else begin
            if (w_q[VAL_W-1]) begin
                w_rnd_sat = 1'b1;
                w_rnd_res = S_MAX;
            end else begin
                w_rnd_res = w_q;
            end
        end
    end

    // saturating series add
    always_comb begin
        w_sum_ext = {r_sum[VAL_W-1], r_sum} + {r_term[VAL_W-1], r_term};
        w_add_sat = (w_sum_ext[VAL_W] != w_sum_ext[VAL_W-1]);
        if (w_add_sat) begin
            w_add_res = w_sum_ext[VAL_W] ? S_MIN : S_MAX;
        end else begin
            w_add_res = w_sum_ext[VAL_W-1:0];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_count <= TERM_W'(15);
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_term_count <= i_cfg.term_count;
            end
            if (i_ctrl.out_wr && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        // new angle beat
        if (w_in_fire) begin
            r_x    <= i_in.angle;
            r_sum  <= ONE;
            r_term <= ONE;
            r_sat  <= 1'b0;
            r_left <= w_n;
            r_i    <= TERM_W'(1);
        end
        // operand load, accumulator preset with the rounding half
        if (i_ctrl.ld) begin
            r_ua  <= w_opa[VAL_W-1] ? -w_opa : w_opa;
            r_ub  <= w_opb[VAL_W-1] ? -w_opb : w_opb;
            r_neg <= (i_ctrl.src == SRC_XX) ? 1'b1 : (w_opa[VAL_W-1] ^ w_opb[VAL_W-1]);
            r_acc <= RND;
        end
        if (i_ctrl.mul_en) begin
            r_prod <= VAL_W'(w_ha) * VAL_W'(w_hb);
        end
        if (i_ctrl.acc_en) begin
            r_acc <= r_acc + w_addend;
        end
        // write back rounded product
        if (i_ctrl.rnd_en) begin
            r_sat <= r_sat | w_rnd_sat;
            case (i_ctrl.dst)
                DST_NEGX2: r_negx2 <= w_rnd_res;
                DST_TERM:  r_term  <= w_rnd_res;
                default:   r_term  <= r_term;
            endcase
        end
        if (i_ctrl.add_en) begin
            r_sum  <= w_add_res;
            r_sat  <= r_sat | w_add_sat;
            r_left <= r_left - TERM_W'(1);
            r_i    <= r_i + TERM_W'(1);
        end
        // result beat
        if (i_ctrl.out_wr && w_out_free) begin
            r_value <= r_sum;
            r_osat  <= r_sat;
        end
    end

endmodule

`default_nettype wire

// ----- src/cos_taylor_series.sv -----
// ----------------------------------------------------------------------------
// cos_taylor_series
// Truncated Taylor-series cosine of a Q7.24 angle, Q39.24 saturating result.
// ----------------------------------------------------------------------------
// One angle beat gives one result beat. The block works on one angle at a
// time: a microcoded sequencer drives one shared 32x32 multiplier, and every
// fixed-point product takes seven steps (operand load, four partial products,
// a final accumulate, round and clamp). The series sums term_count terms,
// clamped to MAX_TERMS, with a reset value of 15. The result is written
// once the output register is free, and only then is the next angle
// taken. A finished result waits in the output register while the next
// angle is accepted. term_count is to be written only while the block is
// idle; the block itself does not enforce it. Its channel is always ready.
// saturated reports any clamp of a product or of the running sum.
// ----------------------------------------------------------------------------
`default_nettype none

module cos_taylor_series import cts_pkg::*; #(
    parameter int MAX_TERMS = 15,
    parameter int FRAC_BITS = 24
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cts_in_if.sink    i_in,
    cts_out_if.source o_out,
    cts_cfg_if.sink   i_cfg
);

    t_ctrl w_ctrl;
    t_stat w_stat;

    // microcode sequencer
    cts_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    // arithmetic datapath
    cts_dp #(
        .MAX_TERMS (MAX_TERMS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .o_stat  (w_stat),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cfg   (i_cfg)
    );

endmodule

`default_nettype wire

// ----- src/cts_chk.sv -----
// ----------------------------------------------------------------------------
// cts_chk
// Port-level checks of the cosine block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cts_chk import cts_pkg::*; (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             i_in_ready,
    input wire logic             i_out_valid,
    input wire logic             i_out_ready,
    input wire logic [VAL_W-1:0] i_out_value,
    input wire logic             i_out_saturated
);

    logic w_in_fire;

    assign w_in_fire = i_in_valid && i_in_ready;

    // no result pending right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid after reset");

    // one angle at a time: no beat in the cycle after a beat
    a_in_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> !i_in_ready)
        else $error("input ready right after an input beat");

    // a result never appears in the cycle right after its angle beat
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(w_in_fire))
        else $error("result too soon after input beat");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_value) && $stable(i_out_saturated))
        else $error("stalled result changed");

endmodule

bind cos_taylor_series cts_chk u_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_value     (o_out.value),
    .i_out_saturated (o_out.saturated)
);

`default_nettype wire

// ----- tb/cos_series_checker.sv -----
// ----------------------------------------------------------------------------
// cos_series_checker
// Watches the angle, result and term count channels of the cosine block,
// works out the series value of every accepted angle under the term count
// in force and compares it field by field with the result beats, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module cos_series_checker import cts_pkg::*; #(
    parameter int MAX_TERMS = 15,
    parameter int FRAC_BITS = 24
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cts_in_if         i_in,
    cts_out_if        i_out,
    cts_cfg_if        i_cfg,
    output int        o_fail_count,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [VAL_W-1:0] POS_LIMIT = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] NEG_LIMIT = {1'b1, {(VAL_W-1){1'b0}}};

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    saturated;
    } cos_result_t;

    cos_result_t       pending_cosines[$];
    logic [TERM_W-1:0] terms_now;
    int                fails;

    // signed fixed-point product, rounded half away from zero, clamped
    function automatic logic signed [VAL_W-1:0] mul_round(
        input  logic signed [VAL_W-1:0] a,
        input  logic signed [VAL_W-1:0] b,
        inout  logic                    clamped
    );
        logic [VAL_W-1:0] mag_a;
        logic [VAL_W-1:0] mag_b;
        logic [VAL_W-1:0] mag_q;
        logic [ACC_W-1:0] prod;
        mag_a = a[VAL_W-1] ? (~a + 1'b1) : a;
        mag_b = b[VAL_W-1] ? (~b + 1'b1) : b;
        prod  = {{VAL_W{1'b0}}, mag_a} * {{VAL_W{1'b0}}, mag_b};
        prod  = prod + (ACC_W'(1) << (FRAC_BITS - 1));
        if ((prod >> (VAL_W + FRAC_BITS)) != '0)
            mag_q = '1;
        else
            mag_q = prod[FRAC_BITS +: VAL_W];
        if (a[VAL_W-1] != b[VAL_W-1]) begin
            if (mag_q > NEG_LIMIT) begin
                clamped = 1'b1;
                mag_q   = NEG_LIMIT;
            end
            return ~mag_q + 1'b1;
        end
        if (mag_q > POS_LIMIT) begin
            clamped = 1'b1;
            mag_q   = POS_LIMIT;
        end
        return mag_q;
    endfunction

    // saturating sum of two terms
    function automatic logic signed [VAL_W-1:0] add_clamp(
        input  logic signed [VAL_W-1:0] a,
        input  logic signed [VAL_W-1:0] b,
        inout  logic                    clamped
    );
        logic [VAL_W:0] s;
        s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
        if (s[VAL_W] != s[VAL_W-1]) begin
            clamped = 1'b1;
            return s[VAL_W] ? NEG_LIMIT : POS_LIMIT;
        end
        return s[VAL_W-1:0];
    endfunction

    // rounded reciprocal of (2i-1)(2i)
    function automatic logic signed [VAL_W-1:0] inv_pair(input int i);
        logic [VAL_W-1:0] d;
        d = VAL_W'((2 * i - 1) * (2 * i));
        return ((VAL_W'(1) << FRAC_BITS) + d / 2) / d;
    endfunction

    // truncated cosine series of one angle
    function automatic cos_result_t cosine_series(
        input logic signed [ANGLE_W-1:0] angle,
        input logic [TERM_W-1:0]         terms
    );
        logic signed [VAL_W-1:0] x;
        logic signed [VAL_W-1:0] total;
        logic signed [VAL_W-1:0] term;
        logic signed [VAL_W-1:0] neg_sq;
        logic                    clamped;
        int                      n;
        cos_result_t             r;
        clamped = 1'b0;
        x       = {{(VAL_W-ANGLE_W){angle[ANGLE_W-1]}}, angle};
        total   = VAL_W'(1) << FRAC_BITS;
        term    = total;
        neg_sq  = -mul_round(x, x, clamped);
        n       = (int'(terms) > MAX_TERMS) ? MAX_TERMS : int'(terms);
        for (int i = 1; i <= n; i++) begin
            term  = mul_round(term, inv_pair(i), clamped);
            term  = mul_round(term, neg_sq, clamped);
            total = add_clamp(total, term, clamped);
        end
        r.value     = total;
        r.saturated = clamped;
        return r;
    endfunction

    // result beats first, then the register shadow, then new angles
    always @(posedge i_clk) begin
        cos_result_t want;
        if (!i_rst_n) begin
            terms_now = TERM_W'(15);
            pending_cosines.delete();
            fails = 0;
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (pending_cosines.size() == 0) begin
                    $display("%0t: result beat with nothing expected, actual %0d sat %0b",
                             $time, $signed(i_out.value), i_out.saturated);
                    fails++;
                end else begin
                    want = pending_cosines.pop_front();
                    if (i_out.value !== want.value) begin
                        $display("%0t: value mismatch, expected %0d, actual %0d",
                                 $time, $signed(want.value), $signed(i_out.value));
                        fails++;
                    end
                    if (i_out.saturated !== want.saturated) begin
                        $display("%0t: saturated mismatch, expected %0b, actual %0b",
                                 $time, want.saturated, i_out.saturated);
                        fails++;
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready)
                terms_now = i_cfg.term_count;
            if (i_in.valid && i_in.ready)
                pending_cosines.push_back(cosine_series(i_in.angle, terms_now));
        end
        o_fail_count <= fails;
        o_pending    <= pending_cosines.size();
    end

endmodule

`default_nettype wire

// ----- tb/tb_cos_taylor_series.sv -----
// ----------------------------------------------------------------------------
// tb_cos_taylor_series
// Drives angles and term count writes into the cosine block with random
// stalls on both channels; a checker beside the block predicts and compares
// every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_cos_taylor_series import cts_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASE_ITEMS = 190;
    localparam int TAIL_CYCLES = 240;
    localparam int ANY_TERMS   = -1;
    // 4*pi in Q7.24
    localparam int FOUR_PI     = 210828714;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   idle_pct;
    int   stall_left;

    cts_in_if  angle_ch();
    cts_out_if result_ch();
    cts_cfg_if cfg_ch();

    cos_taylor_series dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (angle_ch),
        .o_out   (result_ch),
        .i_cfg   (cfg_ch)
    );

    cos_series_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (angle_ch),
        .i_out        (result_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #4 clk = ~clk;

    // result side back-pressure in random bursts
    always @(posedge clk) begin
        if (stall_left != 0) begin
            stall_left      <= stall_left - 1;
            result_ch.ready <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            stall_left      <= $urandom_range(0, 6);
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= 1'b1;
        end
    end

    // hold one angle beat until it is taken; valid stays up for the next one
    task automatic send_angle(input logic [ANGLE_W-1:0] a);
        angle_ch.valid <= 1'b1;
        angle_ch.angle <= a;
        do @(posedge clk); while (!angle_ch.ready);
    endtask

    task automatic hold_off(input int n);
        angle_ch.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // stop sending until every result is back
    task automatic drain();
        angle_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_terms(input logic [TERM_W-1:0] n);
        drain();
        cfg_ch.valid      <= 1'b1;
        cfg_ch.term_count <= n;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // mix of wide, in-range, tiny, edge and power-of-two angles
    function automatic logic [ANGLE_W-1:0] pick_angle();
        int          sel;
        logic [31:0] a;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1, 2: begin
                a = $urandom;
            end
            3, 4, 5, 6: begin
                a = 32'(int'($urandom_range(0, 2 * FOUR_PI)) - FOUR_PI);
            end
            7: begin
                a = 32'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
            end
            8: begin
                a = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'h7fff_fff0}
                    + 32'($urandom_range(0, 31));
            end
            default: begin
                a = 32'd1 << $urandom_range(0, 30);
                if ($urandom_range(0, 1) != 0)
                    a = -a;
            end
        endcase
        return a;
    endfunction

    initial begin
        logic [ANGLE_W-1:0] edge_angles[9];
        int                 phase_terms[10];
        int                 t;
        edge_angles = '{32'd0, 32'h0100_0000, 32'hff00_0000, 32'd52707179,
                        32'd26353589, 32'h7fff_ffff, 32'h8000_0000, 32'd1, 32'hffff_ffff};
        phase_terms = '{0, 15, 1, 14, 2, 8, ANY_TERMS, ANY_TERMS, 15, ANY_TERMS};

        angle_ch.valid    = 1'b0;
        angle_ch.angle    = '0;
        result_ch.ready   = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.term_count = '0;
        stall_left        = 0;
        idle_pct          = 0;
        rst_n             = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset term count, then none, one and two terms
        idle_pct = 20;
        foreach (edge_angles[k])
            send_angle(edge_angles[k]);
        write_terms(TERM_W'(0));
        send_angle(32'h7fff_ffff);
        send_angle(32'h8000_0000);
        send_angle(32'd12345);
        write_terms(TERM_W'(1));
        send_angle(32'h0100_0000);
        send_angle(32'h7fff_ffff);
        send_angle(32'h8000_0000);
        write_terms(TERM_W'(2));
        send_angle(32'd52707179);
        send_angle(32'hfcdc_bd55);

        // random phases over several term counts, last one without idling
        foreach (phase_terms[p]) begin
            t = (phase_terms[p] == ANY_TERMS) ? $urandom_range(0, 15) : phase_terms[p];
            write_terms(TERM_W'(t));
            if (p == 9 || p % 3 == 1)
                idle_pct = 0;
            else
                idle_pct = $urandom_range(10, 40);
            repeat (PHASE_ITEMS) begin
                if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
                    hold_off($urandom_range(1, 7));
                if ($urandom_range(0, 199) == 0)
                    drain();
                send_angle(pick_angle());
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // hard stop far beyond the slowest correct run
    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
